// ----- src/gbf_pkg.sv -----
// Shared types and constants for the graph bridge finder.
package gbf_pkg;

  localparam int VC_W     = 7;
  localparam int BRIDGE_W = 10;
  localparam int PADDR_W  = 2;

  localparam logic [VC_W-1:0]    VC_RESET = 7'd64;
  localparam logic [PADDR_W-1:0] ADDR_VC  = 2'd0;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_LD_RD    = 10'b0000000010,
    S_LD_CHK   = 10'b0000000100,
    S_LD_WB    = 10'b0000001000,
    S_FETCH    = 10'b0000010000,
    S_SCAN     = 10'b0000100000,
    S_BACK     = 10'b0001000000,
    S_POP_UPD  = 10'b0010000000,
    S_POP_EMIT = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic row_re;
    logic row_we;
    logic pair_re;
    logic pair_we;
    logic clear;
  } store_ctl_t;

endpackage

// ----- src/graph_bridge_finder_top.sv -----
// Top level of the graph bridge finder: sequencer, search stack and ports.
//
// A load item adds one undirected edge in steps: one row read, a check and write of the
// first endpoint's row, and a write of the second endpoint's row. A load that is ignored
// or dropped goes no further than the idle state, and a load of a pair already present
// stops after the check. A start item runs a depth-first search from vertex 1 that scans
// one neighbour slot per cycle, n slots for each reached vertex, where n is
// min(vertex_count, MAX_VERTICES); back edges, descents and returns add steps, and a
// stalled output holds the search. Bridges come out as child vertices finish, the last one
// flagged; a graph with no bridge gives one result with none_found. The edge store is
// emptied at the end of a run through per-row valid bits.
module graph_bridge_finder_top
  import gbf_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [6:0]          in_first_vertex,
  input  logic [6:0]          in_second_vertex,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BRIDGE_W-1:0] out_bridge_edge,
  output logic                out_none_found,
  output logic                out_last
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int PW  = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int ECW = $clog2(MAX_EDGES + 1);

  typedef struct packed {
    logic [VW-1:0] v;
    logic          has_par;
    logic [VW-1:0] par;
    logic [NW-1:0] next;
    logic [VW-1:0] low;
    logic [VW-1:0] ent;
  } frame_t;

  state_t state_r, state_nxt;

  logic [VC_W-1:0]         vc_r;
  logic [ECW-1:0]          edge_cnt_r, edge_cnt_nxt;
  logic [VW-1:0]           ld_a_r, ld_a_nxt, ld_b_r, ld_b_nxt;
  logic [BRIDGE_W-1:0]     num_r, num_nxt;
  frame_t                  cur_r, cur_nxt;
  logic [NW-1:0]           sp_r, sp_nxt;
  logic [NW-1:0]           disc_r, disc_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic [VW-1:0]           ch_v_r, ch_v_nxt;
  logic [VW-1:0]           ch_low_r, ch_low_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [BRIDGE_W-1:0]     pend_r, pend_nxt;
  logic                    out_valid_r;
  logic [BRIDGE_W-1:0]     out_edge_r;
  logic                    out_none_r, out_last_r;

  logic                    emit;
  logic [BRIDGE_W-1:0]     emit_edge;
  logic                    emit_none, emit_last;
  logic                    out_free;

  logic [NW-1:0]           n_w;
  logic                    in_acc;
  logic                    ld_ok;
  logic [VW-1:0]           in_a, in_b;

  store_ctl_t              ctl;
  logic [VW-1:0]           row_raddr, row_waddr;
  logic [MAX_VERTICES-1:0] row_wdata, row_rdata;
  logic [PW-1:0]           pair_raddr, pair_waddr;
  logic [BRIDGE_W-1:0]     pair_rdata;

  frame_t                  stk_mem [MAX_VERTICES];
  frame_t                  stk_rd_r;
  logic                    stk_we, stk_re;
  logic [VW-1:0]           stk_waddr, stk_raddr;

  logic [VW-1:0]           ent_mem [MAX_VERTICES];
  logic [VW-1:0]           ent_rd_r;
  logic                    ent_we, ent_re;
  logic [VW-1:0]           ent_addr;
  logic [VW-1:0]           ent_wdata;

  logic [VW-1:0]           scan_i;
  logic [VW-1:0]           par_low;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = 32'(vc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_VC) begin
      vc_r <= pwdata[VC_W-1:0];
    end
  end

  assign n_w = (32'(vc_r) < 32'(MAX_VERTICES)) ? NW'(vc_r) : NW'(MAX_VERTICES);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign ld_ok = (in_first_vertex != 7'd0) && (in_second_vertex != 7'd0)
              && (32'(in_first_vertex) <= 32'(n_w)) && (32'(in_second_vertex) <= 32'(n_w))
              && (in_first_vertex != in_second_vertex);
  assign in_a  = VW'(7'(in_first_vertex - 7'd1));
  assign in_b  = VW'(7'(in_second_vertex - 7'd1));

  assign out_free = !out_valid_r || !out_stall;
  assign scan_i   = cur_r.next[VW-1:0];
  assign par_low  = (ch_low_r < stk_rd_r.low) ? ch_low_r : stk_rd_r.low;

  always_comb begin
    state_nxt    = state_r;
    edge_cnt_nxt = edge_cnt_r;
    ld_a_nxt     = ld_a_r;
    ld_b_nxt     = ld_b_r;
    num_nxt      = num_r;
    cur_nxt      = cur_r;
    sp_nxt       = sp_r;
    disc_nxt     = disc_r;
    vis_nxt      = vis_r;
    ch_v_nxt     = ch_v_r;
    ch_low_nxt   = ch_low_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    emit         = 1'b0;
    emit_edge    = pend_r;
    emit_none    = 1'b0;
    emit_last    = 1'b0;
    ctl          = '0;
    row_raddr    = cur_r.v;
    row_waddr    = ld_a_r;
    row_wdata    = row_rdata | (MAX_VERTICES'(1) << ld_b_r);
    pair_raddr   = PW'(32'(stk_rd_r.v) * MAX_VERTICES + 32'(ch_v_r));
    pair_waddr   = PW'(32'(ld_a_r) * MAX_VERTICES + 32'(ld_b_r));
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = VW'(sp_r - NW'(1));
    stk_raddr    = VW'(sp_r - NW'(2));
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_addr     = scan_i;
    ent_wdata    = VW'(disc_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOAD) begin
            if (edge_cnt_r < ECW'(MAX_EDGES)) begin
              edge_cnt_nxt = edge_cnt_r + ECW'(1);
              num_nxt      = BRIDGE_W'(edge_cnt_r);
              ld_a_nxt     = in_a;
              ld_b_nxt     = in_b;
              if (ld_ok) begin
                state_nxt = S_LD_RD;
              end
            end
          end else begin
            vis_nxt      = '0;
            disc_nxt     = '0;
            pend_vld_nxt = 1'b0;
            if (n_w == '0) begin
              state_nxt = S_DONE;
            end else begin
              // The root enters at time zero.
              ent_we     = 1'b1;
              ent_addr   = '0;
              ent_wdata  = '0;
              cur_nxt    = '0;
              vis_nxt[0] = 1'b1;
              disc_nxt   = NW'(1);
              sp_nxt     = NW'(1);
              state_nxt  = S_FETCH;
            end
          end
        end
      end
      S_LD_RD: begin
        ctl.row_re = 1'b1;
        row_raddr  = ld_a_r;
        state_nxt  = S_LD_CHK;
      end
      S_LD_CHK: begin
        // A pair already present keeps its first arrival number.
        if (row_rdata[ld_b_r]) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.row_we  = 1'b1;
          ctl.pair_we = 1'b1;
          ctl.row_re  = 1'b1;
          row_raddr   = ld_b_r;
          state_nxt   = S_LD_WB;
        end
      end
      S_LD_WB: begin
        ctl.row_we  = 1'b1;
        ctl.pair_we = 1'b1;
        row_waddr   = ld_b_r;
        row_wdata   = row_rdata | (MAX_VERTICES'(1) << ld_a_r);
        pair_waddr  = PW'(32'(ld_b_r) * MAX_VERTICES + 32'(ld_a_r));
        state_nxt   = S_IDLE;
      end
      S_FETCH: begin
        ctl.row_re = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (cur_r.next < n_w) begin
          cur_nxt.next = cur_r.next + NW'(1);
          if (!row_rdata[scan_i] || (cur_r.has_par && scan_i == cur_r.par)) begin
            state_nxt = S_SCAN;
          end else if (vis_r[scan_i]) begin
            ent_re    = 1'b1;
            state_nxt = S_BACK;
          end else if (sp_r < NW'(MAX_VERTICES)) begin
            // Save the current frame and descend into the new vertex.
            stk_we          = 1'b1;
            ent_we          = 1'b1;
            vis_nxt[scan_i] = 1'b1;
            cur_nxt.v       = scan_i;
            cur_nxt.has_par = 1'b1;
            cur_nxt.par     = cur_r.v;
            cur_nxt.next    = '0;
            cur_nxt.low     = VW'(disc_r);
            cur_nxt.ent     = VW'(disc_r);
            disc_nxt        = disc_r + NW'(1);
            sp_nxt          = sp_r + NW'(1);
            state_nxt       = S_FETCH;
          end
        end else begin
          sp_nxt = sp_r - NW'(1);
          if (sp_r == NW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            stk_re     = 1'b1;
            ch_v_nxt   = cur_r.v;
            ch_low_nxt = cur_r.low;
            state_nxt  = S_POP_UPD;
          end
        end
      end
      S_BACK: begin
        if (ent_rd_r < cur_r.low) begin
          cur_nxt.low = ent_rd_r;
        end
        state_nxt = S_SCAN;
      end
      S_POP_UPD: begin
        cur_nxt     = stk_rd_r;
        cur_nxt.low = par_low;
        if (ch_low_r > stk_rd_r.ent) begin
          ctl.pair_re = 1'b1;
          state_nxt   = S_POP_EMIT;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_POP_EMIT: begin
        // The previous bridge goes out only now that it is known not to be the last.
        if (!pend_vld_r || out_free) begin
          emit         = pend_vld_r;
          pend_vld_nxt = 1'b1;
          pend_nxt     = pair_rdata;
          state_nxt    = S_FETCH;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_edge    = pend_vld_r ? pend_r : '0;
          emit_none    = !pend_vld_r;
          emit_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          vis_nxt      = '0;
          edge_cnt_nxt = '0;
          ctl.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      edge_cnt_r <= '0;
      sp_r       <= '0;
      disc_r     <= '0;
      vis_r      <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      sp_r       <= sp_nxt;
      disc_r     <= disc_nxt;
      vis_r      <= vis_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_a_r   <= ld_a_nxt;
    ld_b_r   <= ld_b_nxt;
    num_r    <= num_nxt;
    cur_r    <= cur_nxt;
    ch_v_r   <= ch_v_nxt;
    ch_low_r <= ch_low_nxt;
    pend_r   <= pend_nxt;
  end

  function automatic frame_t cur_nxt_saved();
    frame_t f;
    f      = cur_r;
    f.next = cur_r.next + NW'(1);
    return f;
  endfunction

  // Search stack and entry times.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= cur_nxt_saved();
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_edge_r <= emit_edge;
      out_none_r <= emit_none;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bridge_edge = out_edge_r;
  assign out_none_found  = out_none_r;
  assign out_last        = out_last_r;

  gbf_store #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .row_raddr  (row_raddr),
    .row_waddr  (row_waddr),
    .row_wdata  (row_wdata),
    .row_rdata  (row_rdata),
    .pair_raddr (pair_raddr),
    .pair_waddr (pair_waddr),
    .pair_wdata (num_r),
    .pair_rdata (pair_rdata)
  );

endmodule

// ----- src/gbf_store.sv -----
// Edge store: adjacency rows with per-row valid bits and the first-edge table per pair.
module gbf_store
  import gbf_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  store_ctl_t                                      ctl,
  input  logic [$clog2(MAX_VERTICES)-1:0]                 row_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]                 row_waddr,
  input  logic [MAX_VERTICES-1:0]                         row_wdata,
  output logic [MAX_VERTICES-1:0]                         row_rdata,
  input  logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]    pair_raddr,
  input  logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]    pair_waddr,
  input  logic [BRIDGE_W-1:0]                             pair_wdata,
  output logic [BRIDGE_W-1:0]                             pair_rdata
);

  localparam int PD = MAX_VERTICES * MAX_VERTICES;

  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [MAX_VERTICES-1:0] row_rd_r;
  logic                    row_ok_r;
  logic [BRIDGE_W-1:0]     pair_mem [PD];
  logic [BRIDGE_W-1:0]     pair_rd_r;

  // A row that was never written since the last clear reads as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ctl.clear) begin
      row_vld_r <= '0;
    end else if (ctl.row_we) begin
      row_vld_r[row_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (ctl.row_re) begin
      row_rd_r <= row_mem[row_raddr];
      row_ok_r <= row_vld_r[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    if (ctl.pair_re) begin
      pair_rd_r <= pair_mem[pair_raddr];
    end
  end

  assign row_rdata  = row_ok_r ? row_rd_r : '0;
  assign pair_rdata = pair_rd_r;

endmodule

// ----- tb/testbench.sv -----
// Testbench for the graph bridge finder: directed cases and random graphs checked against a bridge predictor.
`timescale 1ns / 100ps

module testbench;
  import gbf_pkg::*;

  localparam int NV = 64;
  localparam int NE = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [BRIDGE_W-1:0] bridge_edge;
    logic                none_found;
    logic                last;
  } bridge_result_t;

  class bridge_scoreboard;
    bit [NV-1:0]    adj_row [NV];
    int unsigned    pair_number [NV*NV];
    int unsigned    edges_held;
    int unsigned    vertex_count;
    bridge_result_t expected_bridges [$];
    int             errors;

    function new();
      foreach (adj_row[i]) adj_row[i] = '0;
      edges_held = 0;
      vertex_count = 32'(VC_RESET);
      errors = 0;
    endfunction

    function void add_edge(int unsigned a1, int unsigned b1);
      int unsigned n;
      int unsigned num;
      n = vertex_count < NV ? vertex_count : NV;
      if (edges_held >= NE) return;
      num = edges_held;
      edges_held++;
      if (a1 < 1 || b1 < 1 || a1 > n || b1 > n || a1 == b1) return;
      if (!adj_row[a1-1][b1-1]) begin
        adj_row[a1-1][b1-1] = 1'b1;
        adj_row[b1-1][a1-1] = 1'b1;
        pair_number[(a1-1)*NV + b1-1] = num;
        pair_number[(b1-1)*NV + a1-1] = num;
      end
    endfunction

    // Iterative depth-first search; the frame stack mirrors the recursion.
    function void find_bridges();
      int unsigned n, sp, clock, found, v, i, p;
      bit          seen [NV];
      int unsigned entry [NV];
      int unsigned low [NV];
      int unsigned fr_vertex [NV];
      int unsigned fr_parent [NV];
      int unsigned fr_next [NV];
      bridge_result_t r;
      n = vertex_count < NV ? vertex_count : NV;
      foreach (seen[k]) seen[k] = 0;
      sp = 0;
      clock = 0;
      found = 0;
      if (n >= 1) begin
        seen[0] = 1; entry[0] = 0; low[0] = 0; clock = 1;
        fr_vertex[0] = 0; fr_parent[0] = NV; fr_next[0] = 0;
        sp = 1;
      end
      while (sp > 0) begin
        v = fr_vertex[sp-1];
        if (fr_next[sp-1] < n) begin
          i = fr_next[sp-1];
          fr_next[sp-1]++;
          if (adj_row[v][i] && i != fr_parent[sp-1]) begin
            if (seen[i]) begin
              if (entry[i] < low[v]) low[v] = entry[i];
            end else if (sp < NV) begin
              seen[i] = 1; entry[i] = clock; low[i] = clock; clock++;
              fr_vertex[sp] = i; fr_parent[sp] = v; fr_next[sp] = 0;
              sp++;
            end
          end
        end else begin
          sp--;
          if (sp > 0) begin
            p = fr_vertex[sp-1];
            if (low[v] < low[p]) low[p] = low[v];
            if (low[v] > entry[p]) begin
              r.bridge_edge = BRIDGE_W'(pair_number[p*NV + v]);
              r.none_found = 1'b0;
              r.last = 1'b0;
              expected_bridges.push_back(r);
              found++;
            end
          end
        end
      end
      if (found == 0) begin
        r.bridge_edge = '0;
        r.none_found = 1'b1;
        r.last = 1'b1;
        expected_bridges.push_back(r);
      end else begin
        expected_bridges[expected_bridges.size()-1].last = 1'b1;
      end
      foreach (adj_row[k]) adj_row[k] = '0;
      edges_held = 0;
    endfunction

    function void note_item(logic kind, int unsigned a1, int unsigned b1);
      if (kind == KIND_LOAD) add_edge(a1, b1);
      else find_bridges();
    endfunction

    function void check_result(logic [BRIDGE_W-1:0] edge_num, logic none, logic fin);
      bridge_result_t e;
      if (expected_bridges.size() == 0) begin
        $error("result with nothing expected: bridge_edge %0d", edge_num);
        errors++;
        return;
      end
      e = expected_bridges.pop_front();
      if (edge_num !== e.bridge_edge) begin
        $error("bridge_edge: expected %0d, got %0d", e.bridge_edge, edge_num);
        errors++;
      end
      if (none !== e.none_found) begin
        $error("none_found: expected %0d, got %0d", e.none_found, none);
        errors++;
      end
      if (fin !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata, prdata;
  logic                pready;
  logic                in_valid, in_stall, in_kind;
  logic [6:0]          in_first_vertex, in_second_vertex;
  logic                out_valid, out_stall;
  logic [BRIDGE_W-1:0] out_bridge_edge;
  logic                out_none_found, out_last;

  bridge_scoreboard sb;
  int               send_idle_pct;
  int               recv_stall_pct;
  int unsigned      cycles;

  graph_bridge_finder_top u_top (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_bridge_edge, out_none_found, out_last);
  end

  task automatic send_item(logic kind, logic [6:0] a1, logic [6:0] b1);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_kind = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_first_vertex = a1;
    in_second_vertex = b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_item(kind, 32'(a1), 32'(b1));
  endtask

  task automatic write_vertex_count(logic [6:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_VC;
    pwdata = {$urandom} & 32'hFFFF_FF80 | 32'(value);
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    sb.vertex_count = 32'(value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Waits out the remaining results.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_bridges.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_start();
    send_item(KIND_START, 7'($urandom), 7'($urandom));
    drain();
  endtask

  task automatic random_graph(int unsigned vc, bit as_tree);
    int unsigned n, loads, a, b;
    n = vc < NV ? vc : NV;
    write_vertex_count(7'(vc));
    if (as_tree) begin
      // Spanning tree with each vertex joined to a random earlier one gives n-1 bridges.
      for (int k = 2; k <= n; k++) begin
        send_item(KIND_LOAD, 7'(k), 7'($urandom_range(1, k - 1)));
      end
    end else begin
      loads = $urandom_range(1, 2 * n + 2);
      for (int k = 0; k < loads; k++) begin
        if ($urandom_range(0, 99) < 88) begin
          a = $urandom_range(1, n);
          b = $urandom_range(1, n);
        end else begin
          a = $urandom_range(0, 127);
          b = $urandom_range(0, 127);
        end
        send_item(KIND_LOAD, 7'(a), 7'(b));
      end
    end
    run_start();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_kind = KIND_LOAD; in_first_vertex = '0; in_second_vertex = '0;
    out_stall = 1'b0;
    send_idle_pct = 8;
    recv_stall_pct = 80;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: bridge, bad endpoints, self-loop, repeated pair, a triangle.
    send_item(KIND_LOAD, 1, 64);
    send_item(KIND_LOAD, 64, 0);
    send_item(KIND_LOAD, 3, 3);
    send_item(KIND_LOAD, 1, 2);
    send_item(KIND_LOAD, 2, 1);
    send_item(KIND_LOAD, 2, 3);
    send_item(KIND_LOAD, 3, 1);
    send_item(KIND_LOAD, 127, 5);
    send_item(KIND_LOAD, 4, 5);
    run_start();
    write_vertex_count(1);
    send_item(KIND_LOAD, 1, 1);
    send_item(KIND_LOAD, 1, 2);
    run_start();
    write_vertex_count(0);
    send_item(KIND_LOAD, 1, 2);
    run_start();
    write_vertex_count(127);
    send_item(KIND_LOAD, 64, 63);
    send_item(KIND_LOAD, 1, 64);
    send_item(KIND_LOAD, 85, 42);
    run_start();

    for (int g = 0; g < 10; g++) begin
      if (g == 3) begin
        send_idle_pct = 80;
        recv_stall_pct = 8;
      end else if (g == 7) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (g == 5) random_graph(64, 1'b1);
      else random_graph($urandom_range(2, 12), $urandom_range(0, 3) == 0);
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bridges.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
